>>> sv/prtp_pkg.sv
`timescale 1ns / 1ps
package prtp_pkg;

    // CORDIC datapath: 32-bit coordinate, 8 guard bits, headroom for gain and pre-rotation
    localparam int CW = 44;
    // angle accumulator, Q30 radians
    localparam int AW = 34;

    localparam logic [1:0] MODE_ROT_Y = 2'd0;
    localparam logic [1:0] MODE_ROT_X = 2'd1;
    localparam logic [1:0] MODE_SHIFT = 2'd2;

    localparam logic [1:0] REG_MODE  = 2'd0;
    localparam logic [1:0] REG_COS   = 2'd1;
    localparam logic [1:0] REG_SIN   = 2'd2;
    localparam logic [1:0] REG_SHIFT = 2'd3;

    localparam logic signed [AW-1:0] HALF_PI_Q30 = 34'sd1686629713;
    localparam logic signed [16:0]   INV_GAIN_Q16 = 17'sd39797;
    localparam logic signed [17:0]   ANGLE_LIMIT = 18'sd25736;

    // one point word as it moves down the pipe
    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic signed [15:0] el;
        logic signed [15:0] az;
        logic               rot;
    } pt_t;

    // arctangent of 2^-i in Q30
    function automatic logic signed [AW-1:0] atan_q30(input int i);
        logic signed [AW-1:0] r;
        case (i)
            0:  r = 34'sd843314857;
            1:  r = 34'sd497837829;
            2:  r = 34'sd263043837;
            3:  r = 34'sd133525159;
            4:  r = 34'sd67021687;
            5:  r = 34'sd33543516;
            6:  r = 34'sd16775851;
            7:  r = 34'sd8388437;
            8:  r = 34'sd4194283;
            9:  r = 34'sd2097149;
            10: r = 34'sd1048576;
            11: r = 34'sd524288;
            12: r = 34'sd262144;
            13: r = 34'sd131072;
            14: r = 34'sd65536;
            15: r = 34'sd32768;
            16: r = 34'sd16384;
            17: r = 34'sd8192;
            18: r = 34'sd4096;
            19: r = 34'sd2048;
            20: r = 34'sd1024;
            21: r = 34'sd512;
            22: r = 34'sd256;
            23: r = 34'sd128;
            default: r = '0;
        endcase
        return r;
    endfunction

    // saturate a 36-bit value to 32 bits
    function automatic logic signed [31:0] sat36(input logic signed [35:0] v);
        logic signed [31:0] r;
        if (v > 36'sd2147483647) begin
            r = 32'sh7fffffff;
        end else if (v < -36'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    // Q30 angle to Q3.13, rounded half up and clamped
    function automatic logic signed [15:0] angle_out(input logic signed [AW-1:0] q);
        logic signed [AW:0] t;
        logic signed [17:0] a;
        logic signed [15:0] r;
        t = {q[AW-1], q} + 35'sd65536;
        a = t[AW:17];
        if (a > ANGLE_LIMIT) begin
            r = ANGLE_LIMIT[15:0];
        end else if (a < -ANGLE_LIMIT) begin
            r = 16'(-ANGLE_LIMIT);
        end else begin
            r = a[15:0];
        end
        return r;
    endfunction

endpackage

>>> sv/prtp_cordic.sv
`timescale 1ns / 1ps
module prtp_cordic #(
    parameter int STAGES = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              en,
    input  logic                              in_valid,
    input  logic signed [prtp_pkg::CW-1:0]    in_x,
    input  logic signed [prtp_pkg::CW-1:0]    in_y,
    input  prtp_pkg::pt_t                     in_pt,
    output logic                              out_valid,
    output logic signed [prtp_pkg::AW-1:0]    out_ang,
    output logic signed [prtp_pkg::CW-1:0]    out_mag,
    output prtp_pkg::pt_t                     out_pt
);
    import prtp_pkg::*;

    logic                 vr [0:STAGES];
    logic                 zr [0:STAGES];
    logic signed [CW-1:0] xr [0:STAGES];
    logic signed [CW-1:0] yr [0:STAGES];
    logic signed [AW-1:0] ar [0:STAGES];
    pt_t                  pr [0:STAGES];

    logic signed [CW-1:0] x0_next, y0_next;
    logic signed [AW-1:0] a0_next;

    // quadrant pre-rotation so the vector starts in the right half plane
    always_comb begin
        x0_next = in_x;
        y0_next = in_y;
        a0_next = '0;
        if (in_x[CW-1]) begin
            if (!in_y[CW-1]) begin
                x0_next = in_y;
                y0_next = -in_x;
                a0_next = HALF_PI_Q30;
            end else begin
                x0_next = -in_y;
                y0_next = in_x;
                a0_next = -HALF_PI_Q30;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vr[0] <= 1'b0;
        end else if (en) begin
            vr[0] <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            xr[0] <= x0_next;
            yr[0] <= y0_next;
            ar[0] <= a0_next;
            zr[0] <= (in_x == '0) && (in_y == '0);
            pr[0] <= in_pt;
        end
    end

    // one micro-rotation per register stage
    for (genvar i = 0; i < STAGES; i++) begin : g_stage
        localparam logic signed [AW-1:0] ATAN_I = atan_q30(i);

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vr[i+1] <= 1'b0;
            end else if (en) begin
                vr[i+1] <= vr[i];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                if (!yr[i][CW-1]) begin
                    xr[i+1] <= xr[i] + (yr[i] >>> i);
                    yr[i+1] <= yr[i] - (xr[i] >>> i);
                    ar[i+1] <= ar[i] + ATAN_I;
                end else begin
                    xr[i+1] <= xr[i] - (yr[i] >>> i);
                    yr[i+1] <= yr[i] + (xr[i] >>> i);
                    ar[i+1] <= ar[i] - ATAN_I;
                end
                zr[i+1] <= zr[i];
                pr[i+1] <= pr[i];
            end
        end
    end

    // zero vector reads as angle 0, magnitude 0
    assign out_valid = vr[STAGES];
    assign out_ang   = zr[STAGES] ? '0 : ar[STAGES];
    assign out_mag   = zr[STAGES] ? '0 : xr[STAGES];
    assign out_pt    = pr[STAGES];

endmodule

>>> sv/point_rigid_transform_polar.sv
`timescale 1ns / 1ps
// Throughput: one word per cycle; two unrolled CORDIC pipelines, one stage per iteration.
// The whole pipe advances together; it holds only while a result waits on m_ready.
// Reset (aresetn low, synchronous) clears all valid bits and loads the registers
// with mode rotate-about-Y, cos 1.0, sin 0 and shift 0.
module point_rigid_transform_polar #(
    parameter int CORDIC_STAGES = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [31:0] s_in_x,
    input  logic signed [31:0] s_in_y,
    input  logic signed [31:0] s_in_z,
    input  logic signed [15:0] s_in_elevation,
    input  logic signed [15:0] s_in_azimuth,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_out_x,
    output logic signed [31:0] m_out_y,
    output logic signed [31:0] m_out_z,
    output logic signed [15:0] m_out_elevation,
    output logic signed [15:0] m_out_azimuth
);
    import prtp_pkg::*;

    logic               en;
    logic [1:0]         mode_reg;
    logic signed [17:0] cos_reg, sin_reg;
    logic signed [31:0] shift_reg;

    assign en        = !m_valid || m_ready;
    assign s_ready   = en;
    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= MODE_ROT_Y;
            cos_reg   <= 18'sd65536;
            sin_reg   <= '0;
            shift_reg <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_MODE:  mode_reg  <= cfg_data[1:0];
                REG_COS:   cos_reg   <= cfg_data[17:0];
                REG_SIN:   sin_reg   <= cfg_data[17:0];
                REG_SHIFT: shift_reg <= cfg_data;
                default:   mode_reg  <= mode_reg;
            endcase
        end
    end

    // stage 1: four products and the translate sum
    logic               v1_reg;
    logic [1:0]         mode1_reg;
    logic signed [49:0] p0_reg, p1_reg, p2_reg, p3_reg;
    logic signed [31:0] x1_reg, y1_reg, z1_reg, tx1_reg;
    logic signed [15:0] el1_reg, az1_reg;
    logic signed [31:0] ma, mb;
    logic signed [32:0] tsum;
    logic signed [31:0] tx_next;

    always_comb begin
        ma = (mode_reg == MODE_ROT_X) ? s_in_y : s_in_x;
        mb = s_in_z;
        tsum = {s_in_x[31], s_in_x} + {shift_reg[31], shift_reg};
        if (tsum[32] != tsum[31]) begin
            tx_next = tsum[32] ? 32'sh80000000 : 32'sh7fffffff;
        end else begin
            tx_next = tsum[31:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mode1_reg <= mode_reg;
            p0_reg    <= cos_reg * ma;
            p1_reg    <= sin_reg * mb;
            p2_reg    <= cos_reg * mb;
            p3_reg    <= sin_reg * ma;
            x1_reg    <= s_in_x;
            y1_reg    <= s_in_y;
            z1_reg    <= s_in_z;
            tx1_reg   <= tx_next;
            el1_reg   <= s_in_elevation;
            az1_reg   <= s_in_azimuth;
        end
    end

    // stage 2: sums, round half up, saturate, pick by mode
    logic               v2_reg;
    pt_t                pt2_reg;
    pt_t                pt2_next;
    logic signed [50:0] r0, r1;
    logic signed [51:0] q0, q1;
    logic signed [31:0] s0, s1;

    always_comb begin
        if (mode1_reg == MODE_ROT_X) begin
            r0 = 51'(p0_reg) - 51'(p1_reg);
        end else begin
            r0 = 51'(p0_reg) + 51'(p1_reg);
        end
        if (mode1_reg == MODE_ROT_X) begin
            r1 = 51'(p2_reg) + 51'(p3_reg);
        end else begin
            r1 = 51'(p2_reg) - 51'(p3_reg);
        end
        q0 = 52'(r0) + 52'sd32768;
        q1 = 52'(r1) + 52'sd32768;
        s0 = sat36(q0[51:16]);
        s1 = sat36(q1[51:16]);
        pt2_next.x   = x1_reg;
        pt2_next.y   = y1_reg;
        pt2_next.z   = z1_reg;
        pt2_next.el  = el1_reg;
        pt2_next.az  = az1_reg;
        pt2_next.rot = 1'b0;
        case (mode1_reg)
            MODE_ROT_Y: begin
                pt2_next.x   = s0;
                pt2_next.z   = s1;
                pt2_next.rot = 1'b1;
            end
            MODE_ROT_X: begin
                pt2_next.y   = s0;
                pt2_next.z   = s1;
                pt2_next.rot = 1'b1;
            end
            MODE_SHIFT: begin
                pt2_next.x = tx1_reg;
            end
            default: begin
                pt2_next.rot = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (en) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pt2_reg <= pt2_next;
        end
    end

    // azimuth CORDIC on (x, y) with guard bits
    logic                 va;
    logic signed [AW-1:0] anga;
    logic signed [CW-1:0] maga;
    pt_t                  pta;

    prtp_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_az (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (v2_reg),
        .in_x      ({{(CW-40){pt2_reg.x[31]}}, pt2_reg.x, 8'd0}),
        .in_y      ({{(CW-40){pt2_reg.y[31]}}, pt2_reg.y, 8'd0}),
        .in_pt     (pt2_reg),
        .out_valid (va),
        .out_ang   (anga),
        .out_mag   (maga),
        .out_pt    (pta)
    );

    // gain correction, split into two partial products
    logic               vm1_reg;
    pt_t                ptm1_reg;
    pt_t                ptm1_next;
    logic signed [38:0] hi_reg;
    logic signed [39:0] lo_reg;

    always_comb begin
        ptm1_next = pta;
        if (pta.rot) begin
            ptm1_next.az = angle_out(anga);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vm1_reg <= 1'b0;
        end else if (en) begin
            vm1_reg <= va;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            hi_reg   <= $signed(maga[CW-1:22]) * INV_GAIN_Q16;
            lo_reg   <= $signed({1'b0, maga[21:0]}) * INV_GAIN_Q16;
            ptm1_reg <= ptm1_next;
        end
    end

    // recombine, round half up: horizontal range with guard bits
    logic                 vm2_reg;
    pt_t                  ptm2_reg;
    logic signed [CW-1:0] h_reg;
    logic signed [61:0]   hs;

    assign hs = {hi_reg[38], hi_reg, 22'd0} + {{22{lo_reg[39]}}, lo_reg} + 62'sd32768;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vm2_reg <= 1'b0;
        end else if (en) begin
            vm2_reg <= vm1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            h_reg    <= hs[CW+15:16];
            ptm2_reg <= ptm1_reg;
        end
    end

    // elevation CORDIC on (range, z)
    logic                 vb;
    logic signed [AW-1:0] angb;
    logic signed [CW-1:0] magb;
    pt_t                  ptb;

    prtp_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_el (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (vm2_reg),
        .in_x      (h_reg),
        .in_y      ({{(CW-40){ptm2_reg.z[31]}}, ptm2_reg.z, 8'd0}),
        .in_pt     (ptm2_reg),
        .out_valid (vb),
        .out_ang   (angb),
        .out_mag   (magb),
        .out_pt    (ptb)
    );

    // output register
    logic               m_valid_reg;
    logic signed [31:0] x_o_reg, y_o_reg, z_o_reg;
    logic signed [15:0] el_o_reg, az_o_reg;
    logic               mag_unused;

    assign mag_unused = ^magb;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= vb;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_o_reg  <= ptb.x;
            y_o_reg  <= ptb.y;
            z_o_reg  <= ptb.z;
            el_o_reg <= ptb.rot ? angle_out(angb) : ptb.el;
            az_o_reg <= ptb.az;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_out_x         = x_o_reg;
    assign m_out_y         = y_o_reg;
    assign m_out_z         = z_o_reg;
    assign m_out_elevation = el_o_reg ^ {15'd0, mag_unused & 1'b0};
    assign m_out_azimuth   = az_o_reg;

endmodule

>>> sv/prtp_checker.sv
`timescale 1ns / 1ps
module prtp_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               cfg_ready,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input logic signed [31:0] m_out_x,
    input logic signed [15:0] m_out_elevation
);

    // no result right after reset
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // a free output side never holds the input
    a_ready_free: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled while output is empty");

    // config port never back-pressures
    a_cfg_ready: assert property (@(posedge aclk) disable iff (!aresetn) cfg_ready)
        else $error("config port not ready");

    // a stalled result stays valid and keeps its x and elevation
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_x) && $stable(m_out_elevation))
        else $error("stalled result changed");

endmodule

bind point_rigid_transform_polar prtp_checker u_prtp_checker (.*);
